FILE: design/brs_pkg.sv
// Shared constants and types for the bounded rejection sampler.
`default_nettype none

package brs_pkg;

    // Width of one random word and of each packed result field.
    localparam int WORD_W  = 16;
    localparam int FIELD_W = 8;

    // Default sizes of the permutation and the per-sequence word budget.
    localparam int DEFAULT_PERM_SIZE   = 256;
    localparam int DEFAULT_WORD_BUDGET = 1024;

    // One past the largest random word.
    localparam logic [WORD_W:0] FULL_RANGE = 17'h10000;

    // Sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } t_state;

    // Status returned by the shared divider.
    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] rem;
    } t_div_status;

endpackage : brs_pkg

`default_nettype wire

FILE: design/bounded_rejection_sampler_top.sv
// An accepted word within budget enters the single bit-serial remainder divider, one word at
// a time; a word that passes the rejection test has its result registered when the division
// finishes, and a word over budget gives its fail result in the cycle after acceptance.
// The input is not ready while a division runs or while an earlier result still waits.
// Reset (synchronous, active low) clears the position, the word count and the output valid.
`default_nettype none

module bounded_rejection_sampler_top #(
    parameter int PERM_SIZE   = brs_pkg::DEFAULT_PERM_SIZE,
    parameter int WORD_BUDGET = brs_pkg::DEFAULT_WORD_BUDGET
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,   // [15:0] rand_word
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,   // [7:0] position, [15:8] sample_value
    output logic             o_m_axis_tlast,
    output logic             o_m_axis_tuser    // [0] fail
);

    localparam int POS_W   = $clog2(PERM_SIZE);
    localparam int BOUND_W = $clog2(PERM_SIZE + 1);
    localparam int USED_W  = $clog2(WORD_BUDGET);
    localparam int WORD_W  = brs_pkg::WORD_W;
    localparam int FIELD_W = brs_pkg::FIELD_W;

    localparam logic [POS_W-1:0]   LAST_POS  = POS_W'(PERM_SIZE - 1);
    localparam logic [USED_W-1:0]  USED_MAX  = USED_W'(WORD_BUDGET - 1);
    localparam logic [BOUND_W-1:0] SIZE_B    = BOUND_W'(PERM_SIZE);

    brs_pkg::t_state      r_state;
    brs_pkg::t_state      n_state;
    brs_pkg::t_div_status div_status;

    logic [POS_W-1:0]   r_pos;
    logic [USED_W-1:0]  r_used;
    logic [WORD_W-1:0]  r_word;

    logic               r_out_valid;
    logic [FIELD_W-1:0] r_out_pos;
    logic [FIELD_W-1:0] r_out_sample;
    logic               r_out_last;
    logic               r_out_fail;

    logic               in_req;
    logic               out_free;
    logic               over_budget;
    logic               div_start;
    logic [BOUND_W-1:0] bound;
    logic [WORD_W:0]    span_end;
    logic               word_ok;
    logic               pos_last;
    logic [WORD_W-1:0]  pos_ext;

    // Bound for the current position and the rejection test on the remainder.
    always_comb begin
        bound       = SIZE_B - BOUND_W'(r_pos);
        span_end    = {1'b0, r_word} - {1'b0, div_status.rem} + (WORD_W + 1)'(bound);
        word_ok     = (span_end <= brs_pkg::FULL_RANGE);
        pos_last    = (r_pos == LAST_POS);
        pos_ext     = WORD_W'(r_pos);
        over_budget = (r_used >= USED_MAX);
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            brs_pkg::ST_IDLE: begin
                if (in_req && !over_budget) begin
                    n_state = brs_pkg::ST_DIV;
                end
            end
            brs_pkg::ST_DIV: begin
                if (div_status.done) begin
                    n_state = brs_pkg::ST_IDLE;
                end
            end
            default: n_state = brs_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        out_free        = !r_out_valid || i_m_axis_tready;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            brs_pkg::ST_IDLE: o_s_axis_tready = out_free;
            brs_pkg::ST_DIV:  o_s_axis_tready = 1'b0;
            default:          o_s_axis_tready = 1'b0;
        endcase
        in_req    = i_s_axis_tvalid && o_s_axis_tready;
        div_start = in_req && !over_budget;
    end

    brs_div #(
        .DIVISOR_W (BOUND_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_s_axis_tdata),
        .i_divisor  (bound),
        .o_status   (div_status)
    );

    // Control state: sequencer, position, word count and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= brs_pkg::ST_IDLE;
            r_pos       <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_req) begin
                if (over_budget) begin
                    r_pos  <= '0;
                    r_used <= '0;
                end else begin
                    r_used <= r_used + 1'b1;
                end
            end
            if (r_state == brs_pkg::ST_DIV && div_status.done && word_ok) begin
                if (pos_last) begin
                    r_pos  <= '0;
                    r_used <= '0;
                end else begin
                    r_pos <= r_pos + 1'b1;
                end
            end
            // A new result takes the output; otherwise a taken result frees it.
            if ((in_req && over_budget) ||
                (r_state == brs_pkg::ST_DIV && div_status.done && word_ok)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Word capture and result payload.
    always_ff @(posedge i_clk) begin
        if (in_req) begin
            r_word <= i_s_axis_tdata;
            if (over_budget) begin
                r_out_pos    <= '0;
                r_out_sample <= '0;
                r_out_last   <= 1'b0;
                r_out_fail   <= 1'b1;
            end
        end
        if (r_state == brs_pkg::ST_DIV && div_status.done && word_ok) begin
            r_out_pos    <= pos_ext[FIELD_W-1:0];
            r_out_sample <= div_status.rem[FIELD_W-1:0];
            r_out_last   <= pos_last;
            r_out_fail   <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_sample, r_out_pos};
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_fail;

    // A fail result carries no position, sample or last flag.
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == 16'h0000 && !o_m_axis_tlast))
        else $error("fail result carries nonzero fields");

    // The word count never passes the budget limit.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_MAX)
        else $error("word count beyond budget");

    // A division started on acceptance always finishes while the sequencer waits for it.
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_status.done |-> (r_state == brs_pkg::ST_DIV))
        else $error("divider finished outside the divide state");

    // A result is only produced from the divide state when the output was free.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == brs_pkg::ST_DIV && div_status.done) |-> !r_out_valid)
        else $error("result would overwrite a pending result");

endmodule : bounded_rejection_sampler_top

`default_nettype wire

FILE: design/brs_div.sv
// Iterative restoring divider that yields the remainder of a 16-bit word, one bit per cycle.
`default_nettype none

module brs_div #(
    parameter int DIVISOR_W = 9
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [brs_pkg::WORD_W-1:0]   i_dividend,
    input  wire logic [DIVISOR_W-1:0]         i_divisor,
    output brs_pkg::t_div_status              o_status
);

    localparam int CNT_W = $clog2(brs_pkg::WORD_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(brs_pkg::WORD_W - 1);

    logic                       r_busy;
    logic                       r_done;
    logic [CNT_W-1:0]           r_cnt;
    logic [brs_pkg::WORD_W-1:0] r_shift;
    logic [DIVISOR_W-1:0]       r_rem;

    logic [DIVISOR_W:0]         trial;
    logic [DIVISOR_W:0]         diff;
    logic [DIVISOR_W-1:0]       n_rem;

    // One restoring step: bring in the next dividend bit and subtract if it fits.
    always_comb begin
        trial = {r_rem, r_shift[brs_pkg::WORD_W-1]};
        diff  = trial - {1'b0, i_divisor};
        if (diff[DIVISOR_W]) begin
            n_rem = trial[DIVISOR_W-1:0];
        end else begin
            n_rem = diff[DIVISOR_W-1:0];
        end
    end

    // Step control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_dividend;
            r_rem   <= '0;
        end else if (r_busy) begin
            r_shift <= {r_shift[brs_pkg::WORD_W-2:0], 1'b0};
            r_rem   <= n_rem;
        end
    end

    assign o_status.done = r_done;
    assign o_status.rem  = brs_pkg::WORD_W'(r_rem);

endmodule : brs_div

`default_nettype wire
